// ===== src/sjfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sjfd_pkg
// Shared types and constants of the shortest-job-first dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package sjfd_pkg;

	localparam int DEFAULT_READY_DEPTH = 16;

	localparam int JOB_W   = 8;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

	// status codes
	localparam logic STATUS_DISPATCH = 1'b0;
	localparam logic STATUS_REJECT   = 1'b1;

	// one ready-table entry
	typedef struct packed {
		logic [JOB_W-1:0]   job;
		logic [BURST_W-1:0] burst;
		logic [TIME_W-1:0]  arrival;
	} slot_t;

endpackage

`default_nettype wire

// ===== src/sjfd_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sjfd_cmd_if
// Command channel: tick or job arrival, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjfd_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [sjfd_pkg::JOB_W-1:0]   job_id;
	logic [sjfd_pkg::BURST_W-1:0] burst_length;

	modport source (output valid, command, job_id, burst_length, input ready);
	modport sink   (input valid, command, job_id, burst_length, output ready);
endinterface

`default_nettype wire

// ===== src/sjfd_res_if.sv =====
// ----------------------------------------------------------------------------
// sjfd_res_if
// Result channel: dispatch report or arrival reject, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjfd_res_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [sjfd_pkg::JOB_W-1:0]  out_job_id;
	logic [sjfd_pkg::TIME_W-1:0] completion_time;
	logic [sjfd_pkg::TIME_W-1:0] turnaround_time;
	logic [sjfd_pkg::TIME_W-1:0] waiting_time;

	modport source (output valid, status, out_job_id, completion_time,
		turnaround_time, waiting_time, input ready);
	modport sink   (input valid, status, out_job_id, completion_time,
		turnaround_time, waiting_time, output ready);
endinterface

`default_nettype wire

// ===== src/sjfd_table.sv =====
// ----------------------------------------------------------------------------
// sjfd_table
// Ready-table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfd_table #(
	parameter int READY_DEPTH = sjfd_pkg::DEFAULT_READY_DEPTH,
	localparam int IDX_W = $clog2(READY_DEPTH)
) (
	input  wire                   clk,
	input  wire                   wr_en,
	input  wire [IDX_W-1:0]       wr_addr,
	input  wire sjfd_pkg::slot_t  wr_data,
	input  wire [IDX_W-1:0]       rd_addr,
	output sjfd_pkg::slot_t       rd_data
);
	import sjfd_pkg::*;

	slot_t mem [READY_DEPTH];
	slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/shortest_job_first_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// shortest_job_first_dispatcher_unit
// Non-preemptive shortest-job-first dispatcher with a compact ready table.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | command, job_id, burst_length
//  res     | out | valid/ready | status, out_job_id, completion_time,
//          |     |             | turnaround_time, waiting_time
//
//  An accepted arrival, or a tick that dispatches nothing, is handled in
//  the idle state; a rejected arrival goes on to the emit step.
//  A dispatching tick reads one held table entry per cycle for the
//  minimum scan, does the time math in one adder (COMP, TURN, WTIME),
//  then makes one move per cycle to close the gap in the table.
//  A result sits in the output register; a new item is taken meanwhile and
//  waits in the emit step only if it has a result of its own.
//  Reset empties the table and clears time and the busy count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_job_first_dispatcher_unit #(
	parameter int READY_DEPTH = sjfd_pkg::DEFAULT_READY_DEPTH
) (
	input  wire      clk,
	input  wire      arst_n,
	sjfd_cmd_if.sink cmd,
	sjfd_res_if.source res
);
	import sjfd_pkg::*;

	localparam int IDX_W = $clog2(READY_DEPTH);
	localparam int OCC_W = $clog2(READY_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_COMP  = 3'd2;
	localparam logic [2:0] ST_TURN  = 3'd3;
	localparam logic [2:0] ST_WTIME = 3'd4;
	localparam logic [2:0] ST_SHIFT = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]         state_q;
	logic [OCC_W-1:0]   occ_q;
	logic [BURST_W-1:0] busy_q;
	logic [TIME_W-1:0]  now_q;
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   best_q;
	logic [IDX_W-1:0]   sh_q;
	slot_t              best_ent_q;

	logic               res_status_q;
	logic [JOB_W-1:0]   res_job_q;
	logic [TIME_W-1:0]  comp_q;
	logic [TIME_W-1:0]  turn_q;
	logic [TIME_W-1:0]  wtime_q;

	logic               out_valid_q;
	logic               out_status_q;
	logic [JOB_W-1:0]   out_job_q;
	logic [TIME_W-1:0]  out_comp_q;
	logic [TIME_W-1:0]  out_turn_q;
	logic [TIME_W-1:0]  out_wtime_q;

	logic               tbl_wr_en;
	logic [IDX_W-1:0]   tbl_wr_addr;
	slot_t              tbl_wr_data;
	logic [IDX_W-1:0]   tbl_rd_addr;
	slot_t              tbl_rd_data;

	logic               accept;
	logic               out_load;
	logic               full;
	logic               can_dispatch;
	logic               scan_take;
	logic               scan_last;
	logic               shift_more;
	logic [TIME_W-1:0]  alu_a;
	logic [TIME_W-1:0]  alu_b;
	logic               alu_sub;
	logic [TIME_W:0]    alu_sum;
	logic [TIME_W-1:0]  now_next;

	assign cmd.ready    = (state_q == ST_IDLE);
	assign accept       = cmd.valid && cmd.ready;
	assign out_load     = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	assign full         = (occ_q == OCC_W'(READY_DEPTH));
	assign can_dispatch = (busy_q == '0) && (occ_q != '0);
	assign scan_take    = (scan_q == '0) || (tbl_rd_data.burst < best_ent_q.burst);
	assign scan_last    = (OCC_W'(scan_q) + OCC_W'(1)) == occ_q;
	assign shift_more   = (OCC_W'(sh_q) + OCC_W'(1)) < occ_q;
	assign now_next     = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);

	// shared adder for the time math; carry out on a subtract means no borrow
	always_comb begin
		unique case (state_q)
			ST_TURN: begin
				alu_a   = comp_q;
				alu_b   = best_ent_q.arrival;
				alu_sub = 1'b1;
			end
			ST_WTIME: begin
				alu_a   = turn_q;
				alu_b   = TIME_W'(best_ent_q.burst);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = now_q;
				alu_b   = TIME_W'(best_ent_q.burst);
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (TIME_W + 1)'(alu_sub);

	// table access
	always_comb begin
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = occ_q[IDX_W-1:0];
		tbl_wr_data = '{job: cmd.job_id, burst: cmd.burst_length, arrival: now_q};
		tbl_rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				tbl_wr_en = accept && (cmd.command == CMD_ARRIVE) && !full;
			end
			ST_SCAN: begin
				tbl_rd_addr = scan_q + IDX_W'(1);
			end
			ST_WTIME: begin
				tbl_rd_addr = best_q + IDX_W'(1);
			end
			ST_SHIFT: begin
				tbl_wr_en   = shift_more;
				tbl_wr_addr = sh_q;
				tbl_wr_data = tbl_rd_data;
				tbl_rd_addr = sh_q + IDX_W'(1) + IDX_W'(1);
			end
			default: begin
				tbl_rd_addr = '0;
			end
		endcase
	end

	sjfd_table #(
		.READY_DEPTH(READY_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			busy_q  <= '0;
			now_q   <= '0;
			scan_q  <= '0;
			best_q  <= '0;
			sh_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_ARRIVE) begin
							if (full) begin
								state_q <= ST_EMIT;
							end else begin
								occ_q <= occ_q + OCC_W'(1);
							end
						end else if (can_dispatch) begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							if (busy_q != '0) begin
								busy_q <= busy_q - BURST_W'(1);
							end
							now_q <= now_next;
						end
					end
				end
				ST_SCAN: begin
					if (scan_take) begin
						best_q <= scan_q;
					end
					if (scan_last) begin
						state_q <= ST_COMP;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_COMP: begin
					state_q <= ST_TURN;
				end
				ST_TURN: begin
					state_q <= ST_WTIME;
				end
				ST_WTIME: begin
					sh_q    <= best_q;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (shift_more) begin
						sh_q <= sh_q + IDX_W'(1);
					end else begin
						// drop the entry, load busy count and advance time
						occ_q   <= occ_q - OCC_W'(1);
						busy_q  <= (best_ent_q.burst == '0) ? '0
							: best_ent_q.burst - BURST_W'(1);
						now_q   <= now_next;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && cmd.command == CMD_ARRIVE && full) begin
			res_status_q <= STATUS_REJECT;
			res_job_q    <= cmd.job_id;
			comp_q       <= '0;
			turn_q       <= '0;
			wtime_q      <= '0;
		end
		if (state_q == ST_SCAN && scan_take) begin
			best_ent_q <= tbl_rd_data;
		end
		if (state_q == ST_COMP) begin
			comp_q <= alu_sum[TIME_W] ? TIME_MAX : alu_sum[TIME_W-1:0];
		end
		if (state_q == ST_TURN) begin
			turn_q <= alu_sum[TIME_W-1:0];
		end
		if (state_q == ST_WTIME) begin
			wtime_q <= alu_sum[TIME_W] ? alu_sum[TIME_W-1:0] : '0;
		end
		if (state_q == ST_SHIFT && !shift_more) begin
			res_status_q <= STATUS_DISPATCH;
			res_job_q    <= best_ent_q.job;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_job_q    <= res_job_q;
			out_comp_q   <= comp_q;
			out_turn_q   <= turn_q;
			out_wtime_q  <= wtime_q;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = out_status_q;
	assign res.out_job_id      = out_job_q;
	assign res.completion_time = out_comp_q;
	assign res.turnaround_time = out_turn_q;
	assign res.waiting_time    = out_wtime_q;

endmodule

`default_nettype wire
